>>> src/tkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared constants and types for the smallest-value tracker.
// ----------------------------------------------------------------------------
package tkst_pkg;

    localparam int ENTRIES_MAX = 16;
    localparam int CNT_W       = $clog2(ENTRIES_MAX + 1);
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 3;
    localparam int OUT_DATA_W  = 16;

    // Item kinds carried on s_axis_tuser.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Register map.
    localparam logic [ADDR_W-1:0] CAPACITY_ADDR  = 3'd0;
    localparam logic [CNT_W-1:0]  CAPACITY_RESET = CNT_W'(ENTRIES_MAX);
    localparam logic [CNT_W-1:0]  CNT_FULL       = CNT_W'(ENTRIES_MAX);

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                      add_en;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

>>> src/tkst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the sorted row: holds an entry, compares it with the key and
// takes either its own entry, the key or the left neighbour's entry.
// ----------------------------------------------------------------------------
module tkst_cell (
    input  logic                               aclk,
    input  tkst_pkg::cell_ctrl_t               ctrl,
    input  logic                               occupied,
    input  logic signed [tkst_pkg::VALUE_W-1:0] prev_entry,
    input  logic                               prev_shift,
    output logic signed [tkst_pkg::VALUE_W-1:0] entry,
    output logic                               shift,
    output logic                               match
);

    logic signed [tkst_pkg::VALUE_W-1:0] entry_reg;
    logic signed [tkst_pkg::VALUE_W-1:0] entry_next;

    // A slot moves when it is empty or holds a strictly larger value, so a new
    // value lands after any equal entries.
    assign shift = !occupied || (entry_reg > ctrl.key);
    assign match = occupied && (entry_reg == ctrl.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.add_en && shift) begin
            entry_next = prev_shift ? prev_entry : ctrl.key;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> src/top_k_smallest_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_smallest_tracker_core
// Keeps the smallest signed values seen so far in ascending order.
// ----------------------------------------------------------------------------
// Input transactions arrive on s_axis: tdata carries the signed value and
// tuser the kind (add or lookup). Each accepted transaction gives exactly one
// result on m_axis carrying the rank of the first equal entry, the flag that
// says whether the last added value is the smallest held, and the count held.
// In the cycle of acceptance a row of cells compares the value with every
// entry and, for an add, shifts larger entries one slot right. Then, once the
// output register is free, the same comparators search the updated row for
// the value and the result is loaded into the output register. The block
// takes no new item until the search of the last one has finished.
// The output register holds a finished result while the receiver stalls;
// the block takes the next item meanwhile and then waits with its search
// until the register is free. Reset empties the list, sets the last added
// value to minus one and the capacity register to sixteen; entries are not
// cleared. The capacity register lies at address 0 of the APB port and
// should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module top_k_smallest_tracker_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tkst_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic                          s_axis_tuser,  // [0] operation
    // Result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [4:0] rank, [5] last_is_best, [10:6] held_count, [15:11] zero
    output logic [tkst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tkst_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int N  = tkst_pkg::ENTRIES_MAX;
    localparam int CW = tkst_pkg::CNT_W;

    logic [CW-1:0] capacity_reg, capacity_next;
    logic [CW-1:0] count_reg, count_next;
    logic signed [tkst_pkg::VALUE_W-1:0] last_added_reg, last_added_next;
    logic signed [tkst_pkg::VALUE_W-1:0] value_reg, value_next;
    logic busy_reg, busy_next;
    logic m_valid_reg, m_valid_next;
    logic [tkst_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    tkst_pkg::cell_ctrl_t ctrl;
    logic signed [tkst_pkg::VALUE_W-1:0] entry_w [N];
    logic [N-1:0] shift_w;
    logic [N-1:0] match_w;
    logic [N-1:0] occupied_w;

    logic          accept;
    logic          finish;
    logic          cfg_write;
    logic [CW-1:0] limit;
    logic [CW-1:0] grown;
    logic [CW-1:0] rank;
    logic          best;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign prdata        = (paddr == tkst_pkg::CAPACITY_ADDR) ?
                           {{(32-CW){1'b0}}, capacity_reg} : 32'd0;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = busy_reg && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The comparators see the incoming value while idle and the stored value
    // during the search.
    assign ctrl = {accept && (s_axis_tuser == tkst_pkg::OP_ADD),
                   busy_reg ? value_reg : $signed(s_axis_tdata)};

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign occupied_w[g] = CW'(g) < count_reg;
            if (g == 0) begin : g_head
                tkst_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .occupied   (occupied_w[g]),
                    .prev_entry (ctrl.key),
                    .prev_shift (1'b0),
                    .entry      (entry_w[g]),
                    .shift      (shift_w[g]),
                    .match      (match_w[g])
                );
            end else begin : g_body
                tkst_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .occupied   (occupied_w[g]),
                    .prev_entry (entry_w[g-1]),
                    .prev_shift (shift_w[g-1]),
                    .entry      (entry_w[g]),
                    .shift      (shift_w[g]),
                    .match      (match_w[g])
                );
            end
        end
    endgenerate

    // Capacity above the row length saturates.
    assign limit = (capacity_reg > tkst_pkg::CNT_FULL) ? tkst_pkg::CNT_FULL : capacity_reg;
    assign grown = count_reg + CW'(1);

    always_comb begin
        rank = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match_w[i]) begin
                rank = CW'(i + 1);
            end
        end
    end

    assign best = (count_reg != '0) && (last_added_reg == entry_w[0]);

    always_comb begin
        capacity_next   = capacity_reg;
        count_next      = count_reg;
        last_added_next = last_added_reg;
        value_next      = value_reg;
        busy_next       = busy_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cfg_write && (paddr == tkst_pkg::CAPACITY_ADDR)) begin
            capacity_next = pwdata[CW-1:0];
        end

        if (accept) begin
            value_next = $signed(s_axis_tdata);
            busy_next  = 1'b1;
            if (ctrl.add_en) begin
                last_added_next = $signed(s_axis_tdata);
                count_next      = (grown > limit) ? limit : grown;
            end
        end

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (finish) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next  = {{(tkst_pkg::OUT_DATA_W - 2*CW - 1){1'b0}}, count_reg, best, rank};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= tkst_pkg::CAPACITY_RESET;
            count_reg      <= '0;
            last_added_reg <= -32'sd1;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            capacity_reg   <= capacity_next;
            count_reg      <= count_next;
            last_added_reg <= last_added_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> src/tkst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks for the smallest-value tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tkst_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tkst_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CW = tkst_pkg::CNT_W;

    logic [CW-1:0] rank;
    logic          best;
    logic [CW-1:0] held;

    assign rank = m_axis_tdata[CW-1:0];
    assign best = m_axis_tdata[CW];
    assign held = m_axis_tdata[2*CW:CW+1];

    // A stalled result transaction stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (held <= tkst_pkg::CNT_FULL) && (rank <= held))
        else $error("rank or count out of range");

    a_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && best |-> (held != '0))
        else $error("best flag set on an empty list");

endmodule

bind top_k_smallest_tracker_core tkst_checker u_tkst_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
